// ----- src/wpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// wpdc_pkg
// Types and constants shared by the word packet deframer with 16-bit sum.
// ----------------------------------------------------------------------------
package wpdc_pkg;

	localparam int WORD_W            = 16;
	localparam int CTRL_W            = 8;
	localparam int COUNT_W           = 6;
	localparam int INDEX_W           = 5;
	localparam int PIDX_W            = 4;
	localparam int CFG_INDEX_W       = 1;
	localparam int CFG_DATA_W        = 8;
	localparam int MAX_PAYLOAD_WORDS = 16;

	localparam logic [CTRL_W-1:0]  HEADER_RESET = 8'h00;
	localparam logic [COUNT_W-1:0] LIMIT_RESET  = 6'd30;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HEADER_BYTE  = 1'b0,
		REG_LENGTH_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_COUNT   = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} phase_t;

	typedef struct packed {
		logic              payload_valid;
		logic [PIDX_W-1:0] payload_index;
		logic [WORD_W-1:0] payload_data;
		logic              packet_ok;
		logic              length_reject;
		logic [CTRL_W-1:0] control_byte;
		logic [WORD_W-1:0] header_misses;
	} result_t;

endpackage

// ----- src/wpdc_if.sv -----
// ----------------------------------------------------------------------------
// wpdc_if
// Valid/ready channels for received words and for frame results.
// ----------------------------------------------------------------------------
interface wpdc_rx_if;
	logic        valid;
	logic        ready;
	logic [15:0] rx_word;

	modport source (output valid, output rx_word, input ready);
	modport sink (input valid, input rx_word, output ready);
endinterface

interface wpdc_res_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [3:0]  payload_index;
	logic [15:0] payload_data;
	logic        packet_ok;
	logic        length_reject;
	logic [7:0]  control_byte;
	logic [15:0] header_misses;

	modport source (
		output valid, output payload_valid, output payload_index, output payload_data,
		output packet_ok, output length_reject, output control_byte,
		output header_misses, input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_index, input payload_data,
		input packet_ok, input length_reject, input control_byte,
		input header_misses, output ready
	);
endinterface

// ----- src/word_packet_deframer_checksum_top.sv -----
// ----------------------------------------------------------------------------
// word_packet_deframer_checksum_top
// Deframes header/count/payload/checksum word packets with a 16-bit sum.
// ----------------------------------------------------------------------------
//  channel   dir   transfer payload
//  rx        in    rx_word
//  res       out   payload_valid/index/data, packet_ok, length_reject,
//                  control_byte, header_misses
//  cfg       in    cfg_we, cfg_index, cfg_data (no read-back)
//
// one word per clock while rx.ready is high; each transfer gives one result
// in the next cycle from the result register, set by the frame state update
// arst_n clears the frame state, the miss count and the result valid flag
// rx.ready drops only while a held result is not taken
module word_packet_deframer_checksum_top import wpdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	wpdc_rx_if.sink                rx,
	wpdc_res_if.source             res
);

	logic    step;
	logic    in_ready;
	result_t result;

	assign rx.ready = in_ready;
	assign step     = rx.valid && in_ready;

	wpdc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.rx_word   (rx.rx_word),
		.result    (result)
	);

	wpdc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.din      (result),
		.in_ready (in_ready),
		.res      (res)
	);

	a_stall_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !rx.ready)
		else $error("word taken while result is stalled");

	a_transfer_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |=> res.valid)
		else $error("accepted word gave no result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $onehot0({res.payload_valid, res.packet_ok, res.length_reject}))
		else $error("more than one frame flag set");

endmodule

// ----- src/wpdc_core.sv -----
// ----------------------------------------------------------------------------
// wpdc_core
// Frame state, configuration registers and the per-word update logic.
// ----------------------------------------------------------------------------
module wpdc_core import wpdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   step,
	input  logic [WORD_W-1:0]      rx_word,
	output result_t                result
);

	phase_t              phase_q, phase_d;
	logic [CTRL_W-1:0]   header_q;
	logic [COUNT_W-1:0]  limit_q;
	logic [CTRL_W-1:0]   ctrl_q, ctrl_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [INDEX_W-1:0]  index_q, index_d;
	logic [WORD_W-1:0]   sum_q, sum_d;
	logic [WORD_W-1:0]   miss_q, miss_d;

	logic                hit;
	logic                too_long;
	logic [INDEX_W-1:0]  index_inc;
	logic [WORD_W-1:0]   sum_add;

	assign hit       = (rx_word[CTRL_W-1:0] == header_q);
	// whole count word against the limit
	assign too_long  = (rx_word > {{(WORD_W-COUNT_W){1'b0}}, limit_q});
	assign index_inc = index_q + INDEX_W'(1);
	assign sum_add   = sum_q + rx_word;

	always_comb begin
		case (phase_q)
			PH_HEADER: begin
				phase_d = hit ? PH_COUNT : PH_HEADER;
			end
			PH_COUNT: begin
				if (too_long) begin
					phase_d = PH_HEADER;
				end else if (rx_word[COUNT_W-1:0] == '0) begin
					phase_d = PH_CHECK;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				phase_d = (index_inc >= count_q[COUNT_W-1:1]) ? PH_CHECK : PH_PAYLOAD;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	always_comb begin
		ctrl_d  = ctrl_q;
		count_d = count_q;
		index_d = index_q;
		sum_d   = sum_q;
		miss_d  = miss_q;
		result  = '0;
		case (phase_q)
			PH_HEADER: begin
				if (hit) begin
					index_d = '0;
					ctrl_d  = rx_word[WORD_W-1:CTRL_W];
					sum_d   = rx_word;
				end else begin
					miss_d = miss_q + WORD_W'(1);
				end
			end
			PH_COUNT: begin
				if (too_long) begin
					ctrl_d               = '0;
					sum_d                = '0;
					result.length_reject = 1'b1;
				end else begin
					count_d = rx_word[COUNT_W-1:0];
					sum_d   = sum_add;
				end
			end
			PH_PAYLOAD: begin
				// overlong words are summed but not shown
				if (32'(index_q) < MAX_PAYLOAD_WORDS) begin
					result.payload_valid = 1'b1;
					result.payload_index = index_q[PIDX_W-1:0];
					result.payload_data  = rx_word;
				end
				sum_d   = sum_add;
				index_d = index_inc;
			end
			default: begin
				result.packet_ok = (rx_word == sum_q);
			end
		endcase
		result.control_byte  = ctrl_d;
		result.header_misses = miss_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER_BYTE:  header_q <= cfg_data;
				REG_LENGTH_LIMIT: limit_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ctrl_q  <= '0;
			count_q <= '0;
			index_q <= '0;
			sum_q   <= '0;
			miss_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ctrl_q  <= ctrl_d;
			count_q <= count_d;
			index_q <= index_d;
			sum_q   <= sum_d;
			miss_q  <= miss_d;
		end
	end

endmodule

// ----- src/wpdc_out_reg.sv -----
// ----------------------------------------------------------------------------
// wpdc_out_reg
// Result register that parts the result channel from the word channel.
// ----------------------------------------------------------------------------
module wpdc_out_reg import wpdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     din,
	output logic        in_ready,
	wpdc_res_if.source  res
);

	logic    valid_q;
	result_t data_q;

	// a new result may enter when the held one leaves in the same cycle
	assign in_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign res.valid         = valid_q;
	assign res.payload_valid = data_q.payload_valid;
	assign res.payload_index = data_q.payload_index;
	assign res.payload_data  = data_q.payload_data;
	assign res.packet_ok     = data_q.packet_ok;
	assign res.length_reject = data_q.length_reject;
	assign res.control_byte  = data_q.control_byte;
	assign res.header_misses = data_q.header_misses;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the word packet deframer. A directed table covers
// reset values, header misses, rejected and zero counts, a count of one
// and checksum pass/fail. Random frames then run under several header and
// length settings. Every result is checked field by field against the
// directed table or a cycle-free model of the frame state.
// ----------------------------------------------------------------------------
module tb;
	import wpdc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int N_PHASES    = 6;

	typedef struct {
		logic [WORD_W-1:0] word;
		bit                known;
		result_t           res;
	} stim_row_t;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	wpdc_rx_if  rx_ch ();
	wpdc_res_if res_ch ();

	word_packet_deframer_checksum_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	always #5 clk = ~clk;

	// frame state mirror
	logic [CTRL_W-1:0]  cfg_header;
	logic [COUNT_W-1:0] cfg_limit;
	phase_t             fr_phase;
	logic [CTRL_W-1:0]  fr_ctrl;
	logic [COUNT_W-1:0] fr_count;
	logic [INDEX_W-1:0] fr_widx;
	logic [WORD_W-1:0]  fr_sum;
	logic [WORD_W-1:0]  fr_misses;
	bit                 miss_wrapped;

	result_t   expected_results[$];
	stim_row_t directed_rows[$];
	bit        idle_en = 1'b1;
	int        err_count, words_sent, good_frames, rejects, payload_words, settings_run;

	function automatic result_t frame_result(bit pv, logic [PIDX_W-1:0] idx,
			logic [WORD_W-1:0] d, bit ok, bit rej, logic [CTRL_W-1:0] ctrl,
			logic [WORD_W-1:0] miss);
		result_t r;
		r.payload_valid = pv;
		r.payload_index = idx;
		r.payload_data  = d;
		r.packet_ok     = ok;
		r.length_reject = rej;
		r.control_byte  = ctrl;
		r.header_misses = miss;
		return r;
	endfunction

	function automatic result_t deframe_word(logic [WORD_W-1:0] w);
		result_t r;
		r = '0;
		case (fr_phase)
			PH_HEADER: begin
				if (w[7:0] == cfg_header) begin
					fr_widx  = '0;
					fr_ctrl  = w[15:8];
					fr_sum   = w;
					fr_phase = PH_COUNT;
				end else begin
					fr_misses = fr_misses + 1'b1;
					if (fr_misses == '0)
						miss_wrapped = 1'b1;
				end
			end
			PH_COUNT: begin
				// the whole word is compared, not just the count bits
				if (w > WORD_W'(cfg_limit)) begin
					fr_phase        = PH_HEADER;
					fr_ctrl         = '0;
					fr_sum          = '0;
					r.length_reject = 1'b1;
				end else begin
					fr_count = w[COUNT_W-1:0];
					fr_sum   = fr_sum + w;
					fr_phase = (fr_count == '0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (fr_widx < MAX_PAYLOAD_WORDS) begin
					r.payload_valid = 1'b1;
					r.payload_index = fr_widx[PIDX_W-1:0];
					r.payload_data  = w;
				end
				fr_sum  = fr_sum + w;
				fr_widx = fr_widx + 1'b1;
				// tested after the increment, so a count of one still takes a word
				if (fr_widx >= (fr_count >> 1))
					fr_phase = PH_CHECK;
			end
			default: begin
				r.packet_ok = (w == fr_sum);
				fr_phase    = PH_HEADER;
			end
		endcase
		r.control_byte  = fr_ctrl;
		r.header_misses = fr_misses;
		return r;
	endfunction

	task automatic send_word(input logic [WORD_W-1:0] w, input bit known = 1'b0,
			input result_t typed = '0);
		result_t r;
		while (idle_en && $urandom_range(99) < 34) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_word <= w;
		do @(posedge clk); while (!rx_ch.ready);
		r = deframe_word(w);
		expected_results.push_back(known ? typed : r);
		words_sent++;
	endtask

	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CTRL_W-1:0] hdr, input logic [COUNT_W-1:0] lim);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEADER_BYTE;
		cfg_data  <= hdr;
		@(posedge clk);
		cfg_header = hdr;
		cfg_index <= REG_LENGTH_LIMIT;
		cfg_data  <= CFG_DATA_W'(lim);
		@(posedge clk);
		cfg_limit = lim;
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [WORD_W-1:0] miss_word();
		logic [WORD_W-1:0] w;
		w = WORD_W'($urandom);
		if (w[7:0] == cfg_header)
			w[7:0] = ~cfg_header;
		return w;
	endfunction

	task automatic send_frame();
		logic [WORD_W-1:0] start, cnt, w, sum;
		int kind, n;
		// get back to header hunting after a broken frame
		while (fr_phase != PH_HEADER)
			send_word(WORD_W'($urandom));
		repeat ($urandom_range(2)) send_word(miss_word());
		kind  = $urandom_range(99);
		start = {8'($urandom), cfg_header};
		if (kind < 5)
			cnt = WORD_W'(cfg_limit) + 1'b1;
		else if (kind < 12)
			cnt = WORD_W'($urandom_range(32'(cfg_limit) + 1, 65535));
		else if (kind < 22)
			cnt = WORD_W'(cfg_limit);
		else
			cnt = WORD_W'($urandom_range(0, 32'(cfg_limit)));
		send_word(start);
		send_word(cnt);
		if (cnt > WORD_W'(cfg_limit))
			return;
		sum = start + cnt;
		n   = (cnt == 0) ? 0 : ((cnt >> 1) == 0) ? 1 : int'(cnt >> 1);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0:       w = '0;
				1:       w = '1;
				default: w = WORD_W'($urandom);
			endcase
			// truncated frame
			if (kind >= 22 && kind < 27 && i == n / 2)
				return;
			send_word(w);
			sum = sum + w;
		end
		send_word((kind >= 85) ? sum ^ WORD_W'($urandom_range(1, 65535)) : sum);
	endtask

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			err_count++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
		end
	endtask

	// result side
	initial begin
		result_t got, want;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = frame_result(res_ch.payload_valid, res_ch.payload_index,
					res_ch.payload_data, res_ch.packet_ok, res_ch.length_reject,
					res_ch.control_byte, res_ch.header_misses);
				good_frames   += int'(got.packet_ok);
				rejects       += int'(got.length_reject);
				payload_words += int'(got.payload_valid);
				if (expected_results.size() == 0) begin
					err_count++;
					$display("%0t: result with none expected, expected none, actual %0h",
						$time, got);
				end else begin
					want = expected_results.pop_front();
					check_field("payload_valid", 32'(want.payload_valid),
						32'(got.payload_valid));
					check_field("payload_index", 32'(want.payload_index),
						32'(got.payload_index));
					check_field("payload_data", 32'(want.payload_data),
						32'(got.payload_data));
					check_field("packet_ok", 32'(want.packet_ok), 32'(got.packet_ok));
					check_field("length_reject", 32'(want.length_reject),
						32'(got.length_reject));
					check_field("control_byte", 32'(want.control_byte),
						32'(got.control_byte));
					check_field("header_misses", 32'(want.header_misses),
						32'(got.header_misses));
				end
			end
			res_ch.ready <= !(idle_en && $urandom_range(99) < 34);
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
				stall = 0;
			else
				stall++;
			if (stall >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL word_packet_deframer_checksum_top");
				$finish;
			end
		end
	end

	initial begin
		logic [CTRL_W-1:0]  hdr_set[N_PHASES];
		logic [COUNT_W-1:0] lim_set[N_PHASES];
		bit                 idle_set[N_PHASES];
		int                 item_set[N_PHASES];
		int                 first;

		cfg_we        <= 1'b0;
		cfg_index     <= REG_HEADER_BYTE;
		cfg_data      <= '0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_word <= '0;
		cfg_header = HEADER_RESET;
		cfg_limit  = LIMIT_RESET;
		fr_phase   = PH_HEADER;
		fr_ctrl    = '0;
		fr_count   = '0;
		fr_widx    = '0;
		fr_sum     = '0;
		fr_misses  = '0;

		// reset values: header 00, limit 30
		directed_rows = '{
			'{16'h1201, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00, 16'd1)},
			'{16'hFFFF, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00, 16'd2)},
			'{16'hAB00, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'hAB, 16'd2)},
			'{16'h0002, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'hAB, 16'd2)},
			'{16'hFFFF, 1'b1, frame_result(1'b1, 4'd0, 16'hFFFF, 1'b0, 1'b0, 8'hAB, 16'd2)},
			'{16'hAB01, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b1, 1'b0, 8'hAB, 16'd2)},
			'{16'h5500, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h55, 16'd2)},
			'{16'h001F, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b1, 8'h00, 16'd2)},
			'{16'h7700, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h77, 16'd2)},
			'{16'h0000, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h77, 16'd2)},
			'{16'h7700, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b1, 1'b0, 8'h77, 16'd2)},
			'{16'h0100, 1'b0, '0},
			'{16'h0001, 1'b0, '0},
			'{16'h1234, 1'b0, '0},
			'{16'h0000, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h01, 16'd2)},
			'{16'h3300, 1'b0, '0},
			'{16'hFFFF, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b1, 8'h00, 16'd2)},
			'{16'h00FF, 1'b1, frame_result(1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00, 16'd3)},
			'{16'hC000, 1'b0, '0},
			'{16'h0006, 1'b0, '0},
			'{16'h0000, 1'b0, '0},
			'{16'h8000, 1'b0, '0},
			'{16'h7FFF, 1'b0, '0},
			'{16'hC005, 1'b0, '0}
		};

		hdr_set  = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'($urandom), 8'($urandom)};
		lim_set  = '{6'd32, 6'd0, 6'd1, 6'd30, 6'($urandom_range(32)), 6'd32};
		idle_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		item_set = '{200, 120, 150, 180, 200, 300};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].res);

		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			write_regs(hdr_set[p], lim_set[p]);
			idle_en = idle_set[p];
			first = words_sent;
			while (words_sent - first < item_set[p]) begin
				send_frame();
				if (p == 4 && words_sent - first >= item_set[p] / 2 &&
						words_sent - first < item_set[p] / 2 + 8)
					drain_results();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("%0d words over %0d register settings: %0d frames passed checksum,",
			words_sent, settings_run + 1, good_frames);
		$display("%0d length rejects, %0d payload words, header miss count wrapped: %0d",
			rejects, payload_words, miss_wrapped);
		if (err_count == 0 && expected_results.size() == 0)
			$display("PASS word_packet_deframer_checksum_top");
		else
			$display("FAIL word_packet_deframer_checksum_top");
		$finish;
	end

endmodule

// ----- sim.f -----
src/wpdc_pkg.sv
src/wpdc_if.sv
src/wpdc_core.sv
src/wpdc_out_reg.sv
src/word_packet_deframer_checksum_top.sv
tb/sv/tb.sv
